// ===== hw/rtl/alpha_blend_recolor_blit_top_defines.svh =====
// Assertion macros used by the blit RTL.
`ifndef ALPHA_BLEND_RECOLOR_BLIT_TOP_DEFINES_SVH
`define ALPHA_BLEND_RECOLOR_BLIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ABRB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ABRB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/abrb_pkg.sv =====
// Package with beat types, register indexes and operation codes of the blit.
package abrb_pkg;

	localparam int PIX_W     = 32;
	localparam int COORD_W   = 10;
	localparam int WIN_END_W = 11;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int BYTE_W    = 8;
	localparam int LANES     = 3;
	localparam int SUM_W     = 16;

	localparam logic [BYTE_W-1:0] ALPHA_FULL = 8'hFF;
	localparam logic [BYTE_W-1:0] ALPHA_NONE = 8'h00;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_COLOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_END   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_END   = 3'd6;

	// Blit modes
	localparam logic [MODE_W-1:0] MODE_BLEND   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FILL    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RECOLOR = 2'd2;

	// Per-pixel operation chosen in the first stage
	localparam logic [1:0] OP_KEEP  = 2'd0;
	localparam logic [1:0] OP_COPY  = 2'd1;
	localparam logic [1:0] OP_BLEND = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0]   src_pixel;
		logic [PIX_W-1:0]   dst_pixel;
		logic [COORD_W-1:0] dst_x;
		logic [COORD_W-1:0] dst_y;
	} blit_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             write_enable;
	} blit_out_t;

endpackage

// ===== hw/rtl/alpha_blend_recolor_blit_top.sv =====
// Alpha-blend blit with fill and colour-key recolour, three-stage pipeline.
//
// One pixel beat enters per clock while pix_stall is low. Its result is
// offered on the result side through three register stages:
// stage 1 holds the window test and colour select, stage 2 holds the
// three weighted sums of the six 8x8 products per pixel, and stage 3
// divides by 255 and makes the final select into the output register.
// Throughput is one pixel per clock whenever the result side takes beats.
// A stall on the result side fills the empty stages first and only then
// stalls the pixel side. Configuration writes are always ready and take
// effect for beats accepted afterwards; write them while idle.
module alpha_blend_recolor_blit_top import abrb_pkg::*; #(
	parameter int SCREEN_W = 1024,
	parameter int SCREEN_H = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  blit_in_t             pix,
	output logic                 res_valid,
	input  logic                 res_stall,
	output blit_out_t            res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data
);

`include "alpha_blend_recolor_blit_top_defines.svh"

	localparam int XW_SCR = $clog2(SCREEN_W + 1);
	localparam int YW_SCR = $clog2(SCREEN_H + 1);
	localparam int XBW    = (XW_SCR > WIN_END_W) ? XW_SCR : WIN_END_W;
	localparam int YBW    = (YW_SCR > WIN_END_W) ? YW_SCR : WIN_END_W;
	localparam logic [XBW-1:0] SCR_X_BOUND = XBW'(SCREEN_W);
	localparam logic [YBW-1:0] SCR_Y_BOUND = YBW'(SCREEN_H);

	// Configuration registers
	logic [MODE_W-1:0]    mode_q;
	logic [PIX_W-1:0]     key_color_q;
	logic [PIX_W-1:0]     new_color_q;
	logic [COORD_W-1:0]   win_x_start_q;
	logic [COORD_W-1:0]   win_y_start_q;
	logic [WIN_END_W-1:0] win_x_end_q;
	logic [WIN_END_W-1:0] win_y_end_q;

	assign cfg_ready = 1'b1;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_BLEND;
			key_color_q   <= '0;
			new_color_q   <= '0;
			win_x_start_q <= '0;
			win_y_start_q <= '0;
			win_x_end_q   <= 11'd1024;
			win_y_end_q   <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:        mode_q        <= cfg_data[MODE_W-1:0];
				REG_KEY_COLOR:   key_color_q   <= cfg_data;
				REG_NEW_COLOR:   new_color_q   <= cfg_data;
				REG_WIN_X_START: win_x_start_q <= cfg_data[COORD_W-1:0];
				REG_WIN_Y_START: win_y_start_q <= cfg_data[COORD_W-1:0];
				REG_WIN_X_END:   win_x_end_q   <= cfg_data[WIN_END_W-1:0];
				REG_WIN_Y_END:   win_y_end_q   <= cfg_data[WIN_END_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage advances when it is empty or the next one advances
	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	assign en3       = !vld_s3 || !res_stall;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign pix_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= pix_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: clip the window, pick the colour and the operation
	logic [XBW-1:0]       x_bound;
	logic [YBW-1:0]       y_bound;
	logic                 in_win;
	logic [BYTE_W-1:0]    alpha;
	logic                 key_hit;
	logic [PIX_W-1:0]     colour;
	logic [1:0]           op;
	logic                 mode_ok;

	always_comb begin
		x_bound = (XBW'(win_x_end_q) < SCR_X_BOUND) ? XBW'(win_x_end_q) : SCR_X_BOUND;
		y_bound = (YBW'(win_y_end_q) < SCR_Y_BOUND) ? YBW'(win_y_end_q) : SCR_Y_BOUND;
		in_win  = (pix.dst_x >= win_x_start_q) && (XBW'(pix.dst_x) < x_bound) &&
			(pix.dst_y >= win_y_start_q) && (YBW'(pix.dst_y) < y_bound);
		alpha   = pix.src_pixel[PIX_W-1 -: BYTE_W];
		key_hit = (pix.src_pixel[LANES*BYTE_W-1:0] == key_color_q[LANES*BYTE_W-1:0]);
		mode_ok = 1'b1;
		case (mode_q)
			MODE_BLEND:   colour = {pix.dst_pixel[PIX_W-1 -: BYTE_W],
				pix.src_pixel[LANES*BYTE_W-1:0]};
			MODE_FILL:    colour = key_color_q;
			MODE_RECOLOR: colour = key_hit ? new_color_q : pix.src_pixel;
			default: begin
				colour  = pix.dst_pixel;
				mode_ok = 1'b0;
			end
		endcase
		if (!in_win || !mode_ok || alpha == ALPHA_NONE)
			op = OP_KEEP;
		else if (alpha == ALPHA_FULL)
			op = OP_COPY;
		else
			op = OP_BLEND;
	end

	logic [PIX_W-1:0]  dst_s1, colour_s1;
	logic [BYTE_W-1:0] alpha_s1;
	logic [1:0]        op_s1;
	logic              we_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			dst_s1    <= pix.dst_pixel;
			colour_s1 <= colour;
			alpha_s1  <= alpha;
			op_s1     <= op;
			we_s1     <= in_win;
		end
	end

	// Stage 2: weighted sum s*a + d*(255-a) per colour byte
	logic [LANES-1:0][SUM_W-1:0] sum;
	logic [BYTE_W-1:0]           inv_alpha;

	always_comb begin
		inv_alpha = ALPHA_FULL - alpha_s1;
		for (int i = 0; i < LANES; i++) begin
			sum[i] = SUM_W'(colour_s1[i*BYTE_W +: BYTE_W]) * SUM_W'(alpha_s1) +
				SUM_W'(dst_s1[i*BYTE_W +: BYTE_W]) * SUM_W'(inv_alpha);
		end
	end

	logic [LANES-1:0][SUM_W-1:0] sum_s2;
	logic [PIX_W-1:0]            dst_s2, colour_s2;
	logic [1:0]                  op_s2;
	logic                        we_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			sum_s2    <= sum;
			dst_s2    <= dst_s1;
			colour_s2 <= colour_s1;
			op_s2     <= op_s1;
			we_s2     <= we_s1;
		end
	end

	// Stage 3: divide by 255, exact for sums up to 255*255, then select the word
	logic [LANES-1:0][SUM_W:0]  quo_wide;
	logic [LANES*BYTE_W-1:0]    mixed;
	blit_out_t                  res_d;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			quo_wide[i] = {1'b0, sum_s2[i]} + {9'd0, sum_s2[i][SUM_W-1 -: BYTE_W]} +
				(SUM_W+1)'(1);
			mixed[i*BYTE_W +: BYTE_W] = quo_wide[i][SUM_W-1 -: BYTE_W];
		end
		res_d.write_enable = we_s2;
		case (op_s2)
			OP_COPY:  res_d.out_pixel = colour_s2;
			OP_BLEND: res_d.out_pixel = {dst_s2[PIX_W-1 -: BYTE_W], mixed};
			default:  res_d.out_pixel = dst_s2;
		endcase
	end

	// A kept beat moving into the output register this cycle
	logic keep_out_s2;
	assign keep_out_s2 = vld_s2 && en3 && (op_s2 == OP_KEEP);

	always_ff @(posedge clk) begin
		if (en3) begin
			res <= res_d;
		end
	end

	assign res_valid = vld_s3;

	// Checks on the pipeline control
	`ABRB_ASSERT_IMP(a_full_stall, pix_stall, vld_s2 && vld_s3 && res_stall, "early stall")
	`ABRB_ASSERT_NXT(a_accept_fills_s1, pix_valid && !pix_stall, vld_s1, "accepted beat lost")
	`ABRB_ASSERT_NXT(a_s2_holds, vld_s2 && !en3, vld_s2 && $stable(sum_s2), "stage 2 lost beat")
	`ABRB_ASSERT_NXT(a_keep_dst, keep_out_s2, res.out_pixel == $past(dst_s2), "kept pixel")

endmodule
